/* hdl/process_fifo_with_keyed_remove_top_assert.svh */
// Assertion macros used by the queue top level.
`ifndef PROCESS_FIFO_WITH_KEYED_REMOVE_TOP_ASSERT_SVH
`define PROCESS_FIFO_WITH_KEYED_REMOVE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PFKR_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PFKR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/pfkr_pkg.sv */
// Shared types and codes for the keyed-remove process queue.
package pfkr_pkg;

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_REMOVE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // Read address source for the entry store.
  typedef enum logic [1:0] {
    RD_HEAD = 2'd0,
    RD_FREE = 2'd1,
    RD_LINK = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic    latch;       // capture request, clear result
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    push;        // link new entry at tail
    logic    pop;         // unlink head, free it
    logic    walk_start;
    logic    walk_step;
    logic    walk_hit;
    logic    rem_fix;     // relink around matched entry
    logic    rem_free;    // free matched entry
    logic    head_cap;    // capture head identifier
    logic    set_sts;
    status_e sts;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;     // nothing queued
    logic can_take;  // an entry is available for push
    logic use_free;  // push takes from free list
    logic hit;       // walked entry matches
    logic last;      // walked entry is the tail
    logic pos_zero;  // walked entry is the head
  } dp_sts_t;

endpackage

/* hdl/pfkr_dpath.sv */
// Datapath: entry store, list pointers, counters and result register.
module pfkr_dpath import pfkr_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 256,
  parameter int unsigned PID_WIDTH   = 16,
  localparam int unsigned IW = $clog2(QUEUE_DEPTH),
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [PID_WIDTH-1:0] entry_pid_i,
  input  dp_cmd_t              cmd_i,
  output dp_sts_t              sts_o,
  output logic [PID_WIDTH-1:0] result_pid_o,
  output logic [1:0]           status_o,
  output logic [PID_WIDTH-1:0] head_pid_o,
  output logic                 queue_empty_o,
  output logic [CW-1:0]        occupancy_o
);

  logic [PID_WIDTH-1:0] ids_mem   [QUEUE_DEPTH];
  logic [IW-1:0]        links_mem [QUEUE_DEPTH];

  logic [PID_WIDTH-1:0] ids_rd_q;
  logic [IW-1:0]        links_rd_q;

  logic [IW-1:0] head_q, tail_q, free_head_q;
  logic [CW-1:0] free_cnt_q, fresh_q, queued_q;

  logic [PID_WIDTH-1:0] pid_q, head_pid_q, res_q;
  status_e              sts_q;
  logic [IW-1:0]        node_q, prev_q, link_q, pos_q;

  logic [IW-1:0]        rd_addr, new_idx;
  logic                 ids_we, links_we;
  logic [IW-1:0]        ids_wa, links_wa, links_wd;
  logic                 empty, use_free, last, pos_zero;

  assign empty    = (queued_q == '0);
  assign use_free = (free_cnt_q != '0);
  assign pos_zero = (pos_q == '0);
  assign last     = (CW'(pos_q) == queued_q - CW'(1));
  assign new_idx  = use_free ? free_head_q : fresh_q[IW-1:0];

  assign sts_o.empty    = empty;
  assign sts_o.can_take = use_free || (fresh_q != CW'(QUEUE_DEPTH));
  assign sts_o.use_free = use_free;
  assign sts_o.hit      = (ids_rd_q == pid_q);
  assign sts_o.last     = last;
  assign sts_o.pos_zero = pos_zero;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_HEAD: rd_addr = head_q;
      RD_FREE: rd_addr = free_head_q;
      RD_LINK: rd_addr = links_rd_q;
      default: rd_addr = head_q;
    endcase
  end

  // One write per store per cycle; the sequencer keeps link writes apart.
  always_comb begin
    ids_we   = 1'b0;
    ids_wa   = new_idx;
    links_we = 1'b0;
    links_wa = tail_q;
    links_wd = new_idx;
    if (cmd_i.push) begin
      ids_we   = 1'b1;
      links_we = !empty;
    end else if (cmd_i.pop) begin
      links_we = 1'b1;
      links_wa = head_q;
      links_wd = free_head_q;
    end else if (cmd_i.rem_fix) begin
      links_we = !pos_zero;
      links_wa = prev_q;
      links_wd = link_q;
    end else if (cmd_i.rem_free) begin
      links_we = 1'b1;
      links_wa = node_q;
      links_wd = free_head_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ids_we) begin
      ids_mem[ids_wa] <= pid_q;
    end
    if (links_we) begin
      links_mem[links_wa] <= links_wd;
    end
    if (cmd_i.rd_en) begin
      ids_rd_q   <= ids_mem[rd_addr];
      links_rd_q <= links_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      free_head_q <= '0;
      free_cnt_q  <= '0;
      fresh_q     <= '0;
      queued_q    <= '0;
    end else if (cmd_i.push) begin
      if (use_free) begin
        free_head_q <= links_rd_q;
        free_cnt_q  <= free_cnt_q - CW'(1);
      end else begin
        fresh_q <= fresh_q + CW'(1);
      end
      if (empty) begin
        head_q <= new_idx;
      end
      tail_q   <= new_idx;
      queued_q <= queued_q + CW'(1);
    end else if (cmd_i.pop) begin
      head_q      <= links_rd_q;
      free_head_q <= head_q;
      free_cnt_q  <= free_cnt_q + CW'(1);
      queued_q    <= queued_q - CW'(1);
    end else if (cmd_i.rem_fix) begin
      if (pos_zero) begin
        head_q <= link_q;
      end else if (last) begin
        tail_q <= prev_q;
      end
    end else if (cmd_i.rem_free) begin
      free_head_q <= node_q;
      free_cnt_q  <= free_cnt_q + CW'(1);
      queued_q    <= queued_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      pid_q <= entry_pid_i;
      res_q <= '0;
      sts_q <= ST_OK;
    end
    if (cmd_i.set_sts) begin
      sts_q <= cmd_i.sts;
    end
    if (cmd_i.push && empty) begin
      head_pid_q <= pid_q;
    end
    if (cmd_i.head_cap) begin
      head_pid_q <= ids_rd_q;
    end
    if (cmd_i.pop || cmd_i.walk_hit) begin
      res_q <= ids_rd_q;
    end
    if (cmd_i.walk_start) begin
      node_q <= head_q;
      prev_q <= '0;
      pos_q  <= '0;
    end
    if (cmd_i.walk_step) begin
      node_q <= links_rd_q;
      prev_q <= node_q;
      pos_q  <= pos_q + IW'(1);
    end
    if (cmd_i.walk_hit) begin
      link_q <= links_rd_q;
    end
    if (cmd_i.load_out) begin
      result_pid_o  <= res_q;
      status_o      <= sts_q;
      head_pid_o    <= empty ? '0 : head_pid_q;
      queue_empty_o <= empty;
      occupancy_o   <= queued_q;
    end
  end

endmodule

/* hdl/pfkr_ctrl.sv */
// Controller: sequences each request over the datapath and owns the handshakes.
module pfkr_ctrl import pfkr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] action_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output dp_cmd_t    cmd_o,
  input  dp_sts_t    sts_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_PUSH_WR,
    S_POP,
    S_POP_UPD,
    S_REM,
    S_WALK,
    S_REM_FIX,
    S_REM_FREE,
    S_HEAD_RD,
    S_HEAD_CAP,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          case (action_e'(action_i))
            ACT_PUSH:   state_d = S_PUSH;
            ACT_POP:    state_d = S_POP;
            ACT_REMOVE: state_d = S_REM;
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_PUSH: begin
        if (!sts_i.can_take) begin
          cmd_o.set_sts = 1'b1;
          cmd_o.sts     = ST_FULL;
          state_d       = S_DONE;
        end else if (sts_i.use_free) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_FREE;
          state_d      = S_PUSH_WR;
        end else begin
          cmd_o.push = 1'b1;
          state_d    = S_DONE;
        end
      end
      S_PUSH_WR: begin
        cmd_o.push = 1'b1;
        state_d    = S_DONE;
      end
      S_POP: begin
        if (sts_i.empty) begin
          cmd_o.set_sts = 1'b1;
          cmd_o.sts     = ST_EMPTY;
          state_d       = S_DONE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_HEAD;
          state_d      = S_POP_UPD;
        end
      end
      S_POP_UPD: begin
        cmd_o.pop = 1'b1;
        state_d   = S_HEAD_RD;
      end
      S_REM: begin
        if (sts_i.empty) begin
          cmd_o.set_sts = 1'b1;
          cmd_o.sts     = ST_EMPTY;
          state_d       = S_DONE;
        end else begin
          cmd_o.walk_start = 1'b1;
          cmd_o.rd_en      = 1'b1;
          cmd_o.rd_sel     = RD_HEAD;
          state_d          = S_WALK;
        end
      end
      S_WALK: begin
        if (sts_i.hit) begin
          cmd_o.walk_hit = 1'b1;
          state_d        = S_REM_FIX;
        end else if (sts_i.last) begin
          cmd_o.set_sts = 1'b1;
          cmd_o.sts     = ST_NOT_FOUND;
          state_d       = S_DONE;
        end else begin
          // follow the link just read; one entry per cycle
          cmd_o.walk_step = 1'b1;
          cmd_o.rd_en     = 1'b1;
          cmd_o.rd_sel    = RD_LINK;
        end
      end
      S_REM_FIX: begin
        cmd_o.rem_fix = 1'b1;
        state_d       = S_REM_FREE;
      end
      S_REM_FREE: begin
        cmd_o.rem_free = 1'b1;
        state_d        = sts_i.pos_zero ? S_HEAD_RD : S_DONE;
      end
      S_HEAD_RD: begin
        if (sts_i.empty) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_HEAD;
          state_d      = S_HEAD_CAP;
        end
      end
      S_HEAD_CAP: begin
        cmd_o.head_cap = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

/* hdl/process_fifo_with_keyed_remove_top.sv */
// Top level of the process-identifier queue with keyed remove.
//
// Process-identifier queue kept as a linked list in a QUEUE_DEPTH-entry
// store. Each request is a push (action 0), a pop (1) or a remove of the
// first entry holding entry_pid (2); code 3 is a no-op that reports ok.
// Freed entries go on a free list and are reused before never-used ones,
// so no clearing pass is needed after reset. Every request yields exactly
// one result carrying the popped/removed identifier, a status code and a
// peek at the queue: head identifier, empty flag and occupancy. Requests
// are handled one at a time. The list walk sets the remove time: one
// entry per cycle through the store's single registered read port. A
// new request can be taken once the last result is registered, while
// that result still waits in the output register for the sink.
module process_fifo_with_keyed_remove_top import pfkr_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 256,
  parameter int unsigned PID_WIDTH   = 16,
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           action_i,
  input  logic [PID_WIDTH-1:0] entry_pid_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [PID_WIDTH-1:0] result_pid_o,
  output logic [1:0]           status_o,
  output logic [PID_WIDTH-1:0] head_pid_o,
  output logic                 queue_empty_o,
  output logic [CW-1:0]        occupancy_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer: one state per store access step.
  pfkr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Entry store, list pointers and result register.
  pfkr_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PID_WIDTH   (PID_WIDTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_pid_i   (entry_pid_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .result_pid_o  (result_pid_o),
    .status_o      (status_o),
    .head_pid_o    (head_pid_o),
    .queue_empty_o (queue_empty_o),
    .occupancy_o   (occupancy_o)
  );

  // Terms for the checks below.
  logic in_fire, out_fail, peek_ok;
  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fail = out_valid_o && (status_o != ST_OK);
  assign peek_ok  = (queue_empty_o == (occupancy_o == '0)) &&
                    (!queue_empty_o || head_pid_o == '0) &&
                    (occupancy_o <= CW'(QUEUE_DEPTH));

`include "process_fifo_with_keyed_remove_top_assert.svh"

  // Requests are serialized: busy right after one is taken.
  `PFKR_ASSERT_NEXT(a_busy_after_accept, in_fire, in_stall_o, "request accepted while busy")
  // Peek fields agree with each other.
  `PFKR_ASSERT_IMPLIES(a_peek_consistent, out_valid_o, peek_ok, "inconsistent peek fields")
  // A failed request never reports an identifier.
  `PFKR_ASSERT_IMPLIES(a_fail_no_pid, out_fail, result_pid_o == '0, "pid on failure")

endmodule

/* test/testbench.sv */
// Self-checking testbench for the keyed-remove process queue.
module testbench import pfkr_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUEUE_DEPTH = 256;
  localparam int unsigned PID_W       = 16;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned OCC_W       = $clog2(QUEUE_DEPTH + 1);

  // Action code 3 has no package member; the block treats it as a no-op.
  localparam logic [1:0] ACT_NOP = 2'd3;

  localparam int unsigned RANDOM_REQS     = 1330;
  localparam int unsigned PHASE_LEN       = 148;   // requests per random phase
  localparam int unsigned N_PHASES        = 9;
  localparam int unsigned HOLD_OFF_AT     = 400;   // results taken before the long stall
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES   = 300;   // longer than a full-list miss walk
  localparam int unsigned CYCLE_LIMIT     = 2_000_000;

  // One result as the block reports it.
  typedef struct packed {
    logic [PID_W-1:0] result_pid;
    status_e          status;
    logic [PID_W-1:0] head_pid;
    logic             queue_empty;
    logic [OCC_W-1:0] occupancy;
  } outcome_t;

  // Row of the directed table; known rows carry a hand-written outcome.
  typedef struct packed {
    logic [1:0]       action;
    logic [PID_W-1:0] pid;
    logic             known;
    outcome_t         outcome;
  } dir_row_t;

  // Clock, reset and block inputs, all known from time zero.
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic [1:0]       action_i    = '0;
  logic [PID_W-1:0] entry_pid_i = '0;
  logic             out_stall_i = 1'b0;

  logic             in_stall_o;
  logic             out_valid_o;
  logic [PID_W-1:0] result_pid_o;
  logic [1:0]       status_o;
  logic [PID_W-1:0] head_pid_o;
  logic             queue_empty_o;
  logic [OCC_W-1:0] occupancy_o;

  process_fifo_with_keyed_remove_top #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .PID_WIDTH  (PID_W)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .entry_pid_i  (entry_pid_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_pid_o (result_pid_o),
    .status_o     (status_o),
    .head_pid_o   (head_pid_o),
    .queue_empty_o(queue_empty_o),
    .occupancy_o  (occupancy_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the queue: linked entry store, free list and never-used counter.
  // ---------------------------------------------------------------------------
  logic [PID_W-1:0] slot_pid  [QUEUE_DEPTH];
  logic [IDX_W-1:0] slot_next [QUEUE_DEPTH];
  logic [IDX_W-1:0] head_idx  = '0;
  logic [IDX_W-1:0] tail_idx  = '0;
  logic [IDX_W-1:0] free_head = '0;
  int unsigned      free_cnt  = 0;
  int unsigned      fresh_idx = 0;
  int unsigned      queued    = 0;

  outcome_t outcomes_due [$];   // outcomes of accepted requests, oldest first
  int unsigned fail_count = 0;
  int unsigned cycles     = 0;

  // Set by the request source together with each payload it presents.
  logic     drv_known = 1'b0;
  outcome_t drv_exp   = '0;

  // Freed entries go to the front of the free list.
  function automatic void release_slot(logic [IDX_W-1:0] idx);
    slot_next[idx] = free_head;
    free_head      = idx;
    free_cnt++;
  endfunction

  // Applies one request to the shadow queue and returns what the block reports.
  function automatic outcome_t queue_op_outcome(logic [1:0] act, logic [PID_W-1:0] pid);
    outcome_t         o;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] node;
    logic [IDX_W-1:0] prev;
    logic             hit;
    int unsigned      pos;
    o        = '0;
    o.status = ST_OK;
    idx      = '0;
    case (act)
      ACT_PUSH: begin
        // recycled entries first, then never-used ones
        if (free_cnt > 0) begin
          idx       = free_head;
          free_head = slot_next[idx];
          free_cnt--;
        end else if (fresh_idx < QUEUE_DEPTH) begin
          idx = IDX_W'(fresh_idx);
          fresh_idx++;
        end else begin
          o.status = ST_FULL;
        end
        if (o.status == ST_OK) begin
          slot_pid[idx] = pid;
          if (queued == 0) head_idx = idx;
          else slot_next[tail_idx] = idx;
          tail_idx = idx;
          queued++;
        end
      end
      ACT_POP: begin
        if (queued == 0) begin
          o.status = ST_EMPTY;
        end else begin
          idx          = head_idx;
          o.result_pid = slot_pid[idx];
          head_idx     = slot_next[idx];
          queued--;
          release_slot(idx);
        end
      end
      ACT_REMOVE: begin
        if (queued == 0) begin
          o.status = ST_EMPTY;
        end else begin
          node = head_idx;
          prev = '0;
          hit  = 1'b0;
          pos  = 0;
          for (int unsigned p = 0; p < queued && !hit; p++) begin
            if (slot_pid[node] == pid) begin
              hit = 1'b1;
              pos = p;
            end else begin
              prev = node;
              node = slot_next[node];
            end
          end
          if (!hit) begin
            o.status = ST_NOT_FOUND;
          end else begin
            o.result_pid = slot_pid[node];
            if (pos == 0) begin
              head_idx = slot_next[node];
            end else begin
              slot_next[prev] = slot_next[node];
              // removing the tail moves it back to the predecessor
              if (pos + 1 == queued) tail_idx = prev;
            end
            queued--;
            release_slot(node);
          end
        end
      end
      default: ;  // no-op code
    endcase
    o.queue_empty = (queued == 0);
    o.head_pid    = (queued == 0) ? '0 : slot_pid[head_idx];
    o.occupancy   = OCC_W'(queued);
    return o;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Both handshakes are sampled here at the rising edge. Results are checked
  // before the request of the same edge is queued, so a result can never be
  // matched against a request accepted in the same cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : handshake_watch
    outcome_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (outcomes_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual pid %0h status %0h",
                   $time, result_pid_o, status_o);
        end else begin
          want = outcomes_due.pop_front();
          compare_field("result_pid",  want.result_pid,  result_pid_o);
          compare_field("status",      want.status,      status_o);
          compare_field("head_pid",    want.head_pid,    head_pid_o);
          compare_field("queue_empty", want.queue_empty, queue_empty_o);
          compare_field("occupancy",   want.occupancy,   occupancy_o);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        // the shadow always advances; a known row only overrides what is expected
        want = queue_op_outcome(action_i, entry_pid_i);
        if (drv_known) want = drv_exp;
        outcomes_due.push_back(want);
      end
    end
  end

  // Run watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: a stall of random length ahead of each result, stretches with
  // no stall at all, and once a long hold-off so the block fills its output
  // register, takes one more request and then stalls the request side.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned gap;
    int unsigned taken;
    bit          no_idle;
    taken   = 0;
    no_idle = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (taken % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (taken == HOLD_OFF_AT) gap = HOLD_OFF_CYCLES;
      repeat (gap) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      taken++;
    end
  end

  // Presents one request after a random gap and holds it until accepted.
  // Random content is chosen at the falling edge, after the shadow has seen
  // the previous request, so removes can aim at identifiers really queued.
  task automatic offer_request(bit no_idle, int unsigned push_pct, bit use_row, dir_row_t row);
    int unsigned      gap;
    int unsigned      pick;
    int unsigned      k;
    logic [1:0]       act;
    logic [PID_W-1:0] pid;
    logic [IDX_W-1:0] node;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    if (use_row) begin
      act       = row.action;
      pid       = row.pid;
      drv_known = row.known;
      drv_exp   = row.outcome;
    end else begin
      drv_known = 1'b0;
      // small pool for duplicates, the extremes, and full-range values
      pick = $urandom_range(0, 99);
      if (pick < 50)      pid = PID_W'($urandom_range(0, 15));
      else if (pick < 60) pid = '1;
      else if (pick < 65) pid = '0;
      else                pid = PID_W'($urandom_range(0, (1 << PID_W) - 1));
      if ($urandom_range(0, 99) < push_pct) begin
        act = ACT_PUSH;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 5)       act = ACT_NOP;
        else if (pick < 45) act = ACT_POP;
        else begin
          act = ACT_REMOVE;
          // mostly aim at a queued entry, the tail often; the rest likely misses
          if (queued > 0 && $urandom_range(0, 9) < 7) begin
            k    = ($urandom_range(0, 4) == 0) ? queued - 1 : $urandom_range(0, queued - 1);
            node = head_idx;
            repeat (k) node = slot_next[node];
            pid = slot_pid[node];
          end
        end
      end
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    entry_pid_i <= pid;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // ---------------------------------------------------------------------------
  // Request source: reset, directed table, random phases, then drain.
  // ---------------------------------------------------------------------------
  initial begin : request_source
    dir_row_t    rows [$];
    int unsigned push_mix [N_PHASES];
    int unsigned phase;
    int unsigned last_phase;
    bit          no_idle;

    // Push share per random phase: fill to full, sit at full, drain to
    // empty and sit there, then mixed traffic at low occupancy.
    push_mix = '{50, 95, 95, 70, 0, 0, 55, 20, 50};

    // Empty queue: pop and remove report empty, no-op reports ok.
    rows.push_back('{ACT_POP,    16'h0000, 1'b1, '{16'h0000, ST_EMPTY, 16'h0000, 1'b1, 0}});
    rows.push_back('{ACT_REMOVE, 16'h1234, 1'b1, '{16'h0000, ST_EMPTY, 16'h0000, 1'b1, 0}});
    rows.push_back('{ACT_NOP,    16'hFFFF, 1'b1, '{16'h0000, ST_OK,    16'h0000, 1'b1, 0}});
    // Extremes of the identifier, a miss, then removal of the tail.
    rows.push_back('{ACT_PUSH,   16'h0000, 1'b1, '{16'h0000, ST_OK,        16'h0000, 1'b0, 1}});
    rows.push_back('{ACT_PUSH,   16'hFFFF, 1'b1, '{16'h0000, ST_OK,        16'h0000, 1'b0, 2}});
    rows.push_back('{ACT_REMOVE, 16'h1234, 1'b1, '{16'h0000, ST_NOT_FOUND, 16'h0000, 1'b0, 2}});
    rows.push_back('{ACT_REMOVE, 16'hFFFF, 1'b1, '{16'hFFFF, ST_OK,        16'h0000, 1'b0, 1}});
    // Push after tail removal must link from the new tail.
    rows.push_back('{ACT_PUSH,   16'h00AA, 1'b1, '{16'h0000, ST_OK, 16'h0000, 1'b0, 2}});
    rows.push_back('{ACT_POP,    16'h0000, 1'b1, '{16'h0000, ST_OK, 16'h00AA, 1'b0, 1}});
    rows.push_back('{ACT_POP,    16'h0000, 1'b1, '{16'h00AA, ST_OK, 16'h0000, 1'b1, 0}});
    // Recycled entries, duplicates: head match, middle match, tail match.
    rows.push_back('{ACT_PUSH,   16'h5555, 1'b0, '0});
    rows.push_back('{ACT_PUSH,   16'hAAAA, 1'b0, '0});
    rows.push_back('{ACT_PUSH,   16'h5555, 1'b0, '0});
    rows.push_back('{ACT_PUSH,   16'h0007, 1'b0, '0});
    rows.push_back('{ACT_REMOVE, 16'h5555, 1'b0, '0});
    rows.push_back('{ACT_REMOVE, 16'h5555, 1'b0, '0});
    rows.push_back('{ACT_REMOVE, 16'h0007, 1'b0, '0});
    rows.push_back('{ACT_PUSH,   16'h8001, 1'b0, '0});
    rows.push_back('{ACT_NOP,    16'h8001, 1'b0, '0});
    rows.push_back('{ACT_REMOVE, 16'h8001, 1'b0, '0});
    rows.push_back('{ACT_POP,    16'h0000, 1'b0, '0});
    // Back to empty.
    rows.push_back('{ACT_POP,    16'h0000, 1'b1, '{16'h0000, ST_EMPTY, 16'h0000, 1'b1, 0}});
    rows.push_back('{ACT_REMOVE, 16'h0000, 1'b1, '{16'h0000, ST_EMPTY, 16'h0000, 1'b1, 0}});

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) offer_request(1'b0, 0, 1'b1, rows[i]);

    last_phase = N_PHASES;
    no_idle    = 1'b0;
    for (int unsigned i = 0; i < RANDOM_REQS; i++) begin
      phase = i / PHASE_LEN;
      if (phase >= N_PHASES) phase = N_PHASES - 1;
      if (phase != last_phase) begin
        no_idle    = ($urandom_range(0, 3) == 0);
        last_phase = phase;
      end
      offer_request(no_idle, push_mix[phase], 1'b0, '0);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Wait out every pending result, then watch for strays.
    while (outcomes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
